// File: rtl/assert_macros.svh
// Assertion helpers for the checker file.
// Each macro expects signals named clk and rst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// File: rtl/hcbp_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hcbp_pkg
// Shared types and constants for the Huffman code bit packer.
// ---------------------------------------------------------------------------
package hcbp_pkg;

    // Field widths
    localparam int FUNC_W      = 2;
    localparam int SYM_W       = 8;
    localparam int CODE_W      = 32;
    localparam int LEN_W       = 6;
    localparam int BYTE_W      = 8;
    localparam int CNT_W       = 4;
    localparam int TOTAL_W     = 32;
    localparam int TABLE_DEPTH = 256;

    // Work queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    // Function codes
    localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ENCODE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FLUSH  = 2'd2;

    // One code table entry
    typedef struct packed {
        logic [CODE_W-1:0] word;
        logic [LEN_W-1:0]  len;
    } tbl_entry_t;

    // One unit of work for the back end; word is left aligned
    typedef struct packed {
        logic              flush;
        logic [CODE_W-1:0] word;
        logic [LEN_W-1:0]  len;
    } work_t;

    // Queue status seen by front and back
    typedef struct packed {
        logic               empty;
        logic [Q_CNT_W-1:0] count;
    } q_status_t;

endpackage

// File: rtl/hcbp_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hcbp_front
// Accepts words, maintains the code table and queues encode/flush work.
// ---------------------------------------------------------------------------
module hcbp_front #(
    parameter int LEN_LIMIT = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_stall,
    input  logic [hcbp_pkg::FUNC_W-1:0]    func,
    input  logic [hcbp_pkg::SYM_W-1:0]     symbol,
    input  logic [hcbp_pkg::CODE_W-1:0]    code_bits,
    input  logic [hcbp_pkg::LEN_W-1:0]     code_length,
    input  hcbp_pkg::q_status_t            q_status,
    output logic                           push,
    output hcbp_pkg::work_t                push_work
);
    import hcbp_pkg::*;

    localparam logic [LEN_W-1:0] LIMIT_L = LEN_W'(LEN_LIMIT);

    tbl_entry_t             tbl_mem [TABLE_DEPTH];
    tbl_entry_t             rd_reg;
    logic [TABLE_DEPTH-1:0] loaded_reg;
    logic                   s1_valid_reg;
    logic                   s1_flush_reg;
    logic                   s1_loaded_reg;
    logic                   accept;
    logic                   is_load;
    logic                   is_work;
    logic [LEN_W-1:0]       len_sat;
    logic [LEN_W-1:0]       use_len;
    logic [Q_CNT_W:0]       pending;

    // Hold off while the queue could not take the word in flight plus one more
    assign pending   = {1'b0, q_status.count} + {{Q_CNT_W{1'b0}}, s1_valid_reg};
    assign req_stall = (pending >= (Q_CNT_W+1)'(Q_DEPTH));
    assign accept    = req_valid && !req_stall;
    assign is_load   = (func == FUNC_LOAD);
    assign is_work   = (func == FUNC_ENCODE) || (func == FUNC_FLUSH);

    // Clamp stored length
    assign len_sat = (code_length > LIMIT_L) ? LIMIT_L : code_length;

    // Table memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (accept && is_load)
        begin
            tbl_mem[symbol] <= '{word: code_bits, len: len_sat};
        end
        if (accept)
        begin
            rd_reg <= tbl_mem[symbol];
        end
    end

    // Loaded flags; an entry never loaded reads as length zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_reg <= '0;
        end
        else if (accept && is_load)
        begin
            loaded_reg[symbol] <= 1'b1;
        end
    end

    // Lookup stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s1_flush_reg  <= 1'b0;
            s1_loaded_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= accept && is_work;
            s1_flush_reg  <= (func == FUNC_FLUSH);
            s1_loaded_reg <= loaded_reg[symbol];
        end
    end

    // Left align the code so its first bit sits at the top
    assign use_len = (s1_loaded_reg && !s1_flush_reg) ? rd_reg.len : '0;

    always_comb
    begin
        push            = s1_valid_reg;
        push_work.flush = s1_flush_reg;
        push_work.len   = use_len;
        push_work.word  = rd_reg.word << (LEN_W'(CODE_W) - use_len);
    end

endmodule

// File: rtl/hcbp_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hcbp_queue
// Small FIFO of work entries between the front and the back end.
// ---------------------------------------------------------------------------
module hcbp_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  hcbp_pkg::work_t     push_work,
    input  logic                pop,
    output hcbp_pkg::work_t     head,
    output hcbp_pkg::q_status_t status
);
    import hcbp_pkg::*;

    work_t               slot_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]  wr_ptr_reg;
    logic [Q_PTR_W-1:0]  rd_ptr_reg;
    logic [Q_CNT_W-1:0]  count_reg;
    logic [Q_CNT_W-1:0]  count_next;

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_work;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    assign head         = slot_reg[rd_ptr_reg];
    assign status.empty = (count_reg == '0);
    assign status.count = count_reg;

endmodule

// File: rtl/hcbp_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hcbp_back
// Bit packer: folds queued codes into bytes and drives the output register.
// ---------------------------------------------------------------------------
module hcbp_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  hcbp_pkg::q_status_t            q_status,
    input  hcbp_pkg::work_t                head,
    output logic                           pop,
    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    output logic [hcbp_pkg::BYTE_W-1:0]    out_byte,
    output logic                           is_last,
    output logic [hcbp_pkg::TOTAL_W-1:0]   bytes_written
);
    import hcbp_pkg::*;

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(BYTE_W);

    logic [BYTE_W-1:0]  pend_reg,    pend_next;
    logic [CNT_W-1:0]   cnt_reg,     cnt_next;
    logic [CODE_W-1:0]  aligned_reg, aligned_next;
    logic [LEN_W-1:0]   rem_reg,     rem_next;
    logic [TOTAL_W-1:0] total_reg,   total_next;
    logic               rsp_valid_reg;
    logic [BYTE_W-1:0]  out_byte_reg;
    logic               is_last_reg;
    logic [TOTAL_W-1:0] bytes_written_reg;

    logic               slot_free;
    logic               busy;
    logic               full;
    logic               emit;
    logic [BYTE_W-1:0]  emit_byte;
    logic               emit_last;
    logic [BYTE_W-1:0]  base;
    logic [CNT_W-1:0]   cnt_b;
    logic [CNT_W-1:0]   room;
    logic [CNT_W-1:0]   take;

    assign slot_free = !rsp_valid_reg || !rsp_stall;
    assign busy      = (rem_reg != '0);
    assign full      = (cnt_reg == FULL_CNT);

    // Fill step: emit a full byte first, then take as many bits as fit
    always_comb
    begin
        base         = full ? '0 : pend_reg;
        cnt_b        = full ? '0 : cnt_reg;
        room         = FULL_CNT - cnt_b;
        take         = (LEN_W'(room) < rem_reg) ? room : rem_reg[CNT_W-1:0];
        pend_next    = pend_reg;
        cnt_next     = cnt_reg;
        aligned_next = aligned_reg;
        rem_next     = rem_reg;
        pop          = 1'b0;
        emit         = 1'b0;
        emit_byte    = pend_reg;
        emit_last    = 1'b0;
        if (busy)
        begin
            if (!full || slot_free)
            begin
                emit         = full;
                pend_next    = base | (aligned_reg[CODE_W-1 -: BYTE_W] >> cnt_b);
                cnt_next     = cnt_b + take;
                aligned_next = aligned_reg << take;
                rem_next     = rem_reg - LEN_W'(take);
            end
        end
        else if (!q_status.empty)
        begin
            if (head.flush)
            begin
                if (slot_free)
                begin
                    pop       = 1'b1;
                    emit      = 1'b1;
                    emit_last = 1'b1;
                    pend_next = '0;
                    cnt_next  = '0;
                end
            end
            else
            begin
                pop          = 1'b1;
                aligned_next = head.word;
                rem_next     = head.len;
            end
        end
    end

    // Saturating byte count
    assign total_next = (total_reg == '1) ? total_reg : total_reg + 1'b1;

    // Packer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= '0;
            cnt_reg       <= '0;
            rem_reg       <= '0;
            total_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= pend_next;
            cnt_reg  <= cnt_next;
            rem_reg  <= rem_next;
            if (emit)
            begin
                total_reg     <= total_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        aligned_reg <= aligned_next;
        if (emit)
        begin
            out_byte_reg      <= emit_byte;
            is_last_reg       <= emit_last;
            bytes_written_reg <= total_next;
        end
    end

    assign rsp_valid     = rsp_valid_reg;
    assign out_byte      = out_byte_reg;
    assign is_last       = is_last_reg;
    assign bytes_written = bytes_written_reg;

endmodule

// File: rtl/huffman_code_bit_packer_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// huffman_code_bit_packer_core
// Huffman back end: loadable code table and MSB-first byte packer.
// ---------------------------------------------------------------------------
// A table load is written into the table when it is accepted. An encode
// word is looked up in the front end and queued. The back end then pops
// the code from the queue. After that it takes, in each step, the group of
// bits that fills the partial byte up to its next byte boundary; a full
// partial byte counts as empty and is pushed out in the step that takes
// the next group. A zero-length code is only popped, and a flush pops and
// pushes out the partial byte, marked last. A step that pushes out a
// byte, and a flush, waits while the output word is stalled. The input
// side runs ahead of the packer by up to four queued words; throughput is
// set by the single packing step in the back end. The code table is
// cleared at reset through per-entry loaded flags, so no clearing pass is
// needed and words are accepted right after reset.
module huffman_code_bit_packer_core #(
    parameter int MAX_CODE_LEN = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_stall,
    input  logic [hcbp_pkg::FUNC_W-1:0]    func,
    input  logic [hcbp_pkg::SYM_W-1:0]     symbol,
    input  logic [hcbp_pkg::CODE_W-1:0]    code_bits,
    input  logic [hcbp_pkg::LEN_W-1:0]     code_length,
    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    output logic [hcbp_pkg::BYTE_W-1:0]    out_byte,
    output logic                           is_last,
    output logic [hcbp_pkg::TOTAL_W-1:0]   bytes_written
);
    import hcbp_pkg::*;

    localparam int LEN_LIMIT = (MAX_CODE_LEN > CODE_W) ? CODE_W : MAX_CODE_LEN;

    q_status_t q_status;
    work_t     push_work;
    work_t     head;
    logic      push;
    logic      pop;

    // Front end: table and lookup
    hcbp_front #(
        .LEN_LIMIT (LEN_LIMIT)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .func        (func),
        .symbol      (symbol),
        .code_bits   (code_bits),
        .code_length (code_length),
        .q_status    (q_status),
        .push        (push),
        .push_work   (push_work)
    );

    // Work queue
    hcbp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_work (push_work),
        .pop       (pop),
        .head      (head),
        .status    (q_status)
    );

    // Back end: packer and output register
    hcbp_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_status      (q_status),
        .head          (head),
        .pop           (pop),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .out_byte      (out_byte),
        .is_last       (is_last),
        .bytes_written (bytes_written)
    );

endmodule

// File: rtl/hcbp_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hcbp_checker
// Port-level checks on the packer's output channel.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module hcbp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        rsp_valid,
    input logic        rsp_stall,
    input logic [7:0]  out_byte,
    input logic        is_last,
    input logic [31:0] bytes_written
);

    // A stalled output word holds
    `ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(out_byte) && $stable(is_last) && $stable(bytes_written))

    // Every emitted word counts itself
    `ASSERT_SAME(a_count_nonzero, rsp_valid, bytes_written != 32'd0)

    // The word after a taken word is counted one higher, or stays saturated
    `ASSERT_NEXT(a_count_step, rsp_valid && !rsp_stall, !rsp_valid || (bytes_written == $past(bytes_written) + 32'd1) || (bytes_written == 32'hFFFFFFFF && $past(bytes_written) == 32'hFFFFFFFF))

endmodule

bind huffman_code_bit_packer_core hcbp_checker u_hcbp_checker (.*);

// File: tb/huffman_code_bit_packer_core_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// huffman_code_bit_packer_core_test
// Self-checking bench for the Huffman code bit packer core.
// A directed table covers the corner cases: empty flush, unloaded and
// zero-length symbols, overlong lengths, stray high code bits and the
// unused function code. A random stream of loads, encodes and flushes
// follows. Every accepted word runs through a bit-level packing model,
// and each output byte is checked in order against it. Both handshakes
// idle at random.
// ---------------------------------------------------------------------------
module huffman_code_bit_packer_core_test;
    import hcbp_pkg::*;

    localparam int MAX_LEN     = 32;
    localparam int LEN_CAP     = (MAX_LEN < CODE_W) ? MAX_LEN : CODE_W;
    localparam int MAX_BYTES   = 4;
    localparam int N_RANDOM    = 150;
    localparam int DRAIN_WAIT  = 40;
    localparam int CYCLE_LIMIT = 200_000;
    localparam int PRINT_LIMIT = 100;

    // Function code with no meaning in the block
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    // One input word
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [SYM_W-1:0]  symbol;
        logic [CODE_W-1:0] code_bits;
        logic [LEN_W-1:0]  code_length;
    } code_req_t;

    // One output byte
    typedef struct packed {
        logic [BYTE_W-1:0]  value;
        logic               last;
        logic [TOTAL_W-1:0] total;
    } byte_rec_t;

    // Directed row; a typed row replaces the model's single byte
    typedef struct packed {
        code_req_t req;
        logic      typed;
        byte_rec_t want;
    } dir_row_t;

    localparam byte_rec_t NO_BYTE = '{8'h00, 1'b0, 32'd0};

    localparam int N_DIRECTED = 22;
    localparam dir_row_t DIRECTED [N_DIRECTED] = '{
        // flush right after reset: empty byte, marked last, count 1
        '{'{FUNC_FLUSH,  8'h00, 32'h0000_0000, 6'd0},  1'b1, '{8'h00, 1'b1, 32'd1}},
        // unloaded symbol packs nothing
        '{'{FUNC_ENCODE, 8'h55, 32'h0000_0000, 6'd0},  1'b0, NO_BYTE},
        // unused code with every field at its top
        '{'{FUNC_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'd63}, 1'b0, NO_BYTE},
        // table loads: full length, single bits, stray high bits, overlong
        '{'{FUNC_LOAD,   8'hFF, 32'hFFFF_FFFF, 6'd32}, 1'b0, NO_BYTE},
        '{'{FUNC_LOAD,   8'h00, 32'h0000_0000, 6'd1},  1'b0, NO_BYTE},
        '{'{FUNC_LOAD,   8'h01, 32'hFFFF_FFFE, 6'd1},  1'b0, NO_BYTE},
        '{'{FUNC_LOAD,   8'h80, 32'h0000_00A5, 6'd8},  1'b0, NO_BYTE},
        '{'{FUNC_LOAD,   8'h7F, 32'h1234_5678, 6'd63}, 1'b0, NO_BYTE},
        '{'{FUNC_LOAD,   8'h02, 32'h8000_0001, 6'd40}, 1'b0, NO_BYTE},
        '{'{FUNC_LOAD,   8'h03, 32'hAAAA_AAAA, 6'd0},  1'b0, NO_BYTE},
        // exactly one full byte waits, nothing out yet
        '{'{FUNC_ENCODE, 8'h80, 32'h0000_0000, 6'd0},  1'b0, NO_BYTE},
        // 32-bit code pushes out four bytes
        '{'{FUNC_ENCODE, 8'hFF, 32'h0000_0000, 6'd0},  1'b0, NO_BYTE},
        '{'{FUNC_FLUSH,  8'h00, 32'h0000_0000, 6'd0},  1'b1, '{8'hFF, 1'b1, 32'd6}},
        // saturated length: all 32 bits of the word
        '{'{FUNC_ENCODE, 8'h7F, 32'h0000_0000, 6'd0},  1'b0, NO_BYTE},
        '{'{FUNC_ENCODE, 8'h00, 32'h0000_0000, 6'd0},  1'b0, NO_BYTE},
        '{'{FUNC_FLUSH,  8'h00, 32'h0000_0000, 6'd0},  1'b1, '{8'h00, 1'b1, 32'd11}},
        // back-to-back flush with nothing pending
        '{'{FUNC_FLUSH,  8'h00, 32'h0000_0000, 6'd0},  1'b1, '{8'h00, 1'b1, 32'd12}},
        // loaded with zero length
        '{'{FUNC_ENCODE, 8'h03, 32'h0000_0000, 6'd0},  1'b0, NO_BYTE},
        '{'{FUNC_ENCODE, 8'h01, 32'h0000_0000, 6'd0},  1'b0, NO_BYTE},
        '{'{FUNC_ENCODE, 8'h02, 32'h0000_0000, 6'd0},  1'b0, NO_BYTE},
        '{'{FUNC_UNUSED, 8'h80, 32'h5A5A_5A5A, 6'd21}, 1'b0, NO_BYTE},
        '{'{FUNC_FLUSH,  8'h00, 32'h0000_0000, 6'd0},  1'b0, NO_BYTE}
    };

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 req_valid;
    logic                 req_stall;
    logic [FUNC_W-1:0]    func;
    logic [SYM_W-1:0]     symbol;
    logic [CODE_W-1:0]    code_bits;
    logic [LEN_W-1:0]     code_length;
    logic                 rsp_valid;
    logic                 rsp_stall;
    logic [BYTE_W-1:0]    out_byte;
    logic                 is_last;
    logic [TOTAL_W-1:0]   bytes_written;

    // Packing model state
    logic [CODE_W-1:0]    code_word_mem [TABLE_DEPTH] = '{default: '0};
    logic [LEN_W-1:0]     code_len_mem [TABLE_DEPTH]  = '{default: '0};
    logic [BYTE_W-1:0]    acc_byte      = '0;
    int                   acc_count     = 0;
    logic [TOTAL_W-1:0]   emitted_total = '0;

    byte_rec_t            expected_bytes [$];
    int                   loaded_syms [$];
    int                   mismatch_count = 0;
    int                   cycle_count    = 0;
    bit                   steady         = 1'b0;

    huffman_code_bit_packer_core #(
        .MAX_CODE_LEN (MAX_LEN)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .func          (func),
        .symbol        (symbol),
        .code_bits     (code_bits),
        .code_length   (code_length),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .out_byte      (out_byte),
        .is_last       (is_last),
        .bytes_written (bytes_written)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Idle cycles before the next word on either side
    function automatic int draw_wait();
        return steady ? 0 : $urandom_range(0, 16);
    endfunction

    // Count a byte (saturating) and queue it
    function automatic void queue_byte(input logic [BYTE_W-1:0] value, input logic last);
        if (emitted_total != '1)
            emitted_total = emitted_total + 1'b1;
        expected_bytes.push_back('{value, last, emitted_total});
    endfunction

    // Bit packer model: queues the bytes one word releases, returns how many
    function automatic int pack_word(input code_req_t w);
        int                n;
        int                len;
        logic [CODE_W-1:0] cw;
        n = 0;
        case (w.func)
            FUNC_LOAD:
            begin
                len = w.code_length;
                if (len > LEN_CAP)
                    len = LEN_CAP;
                code_word_mem[w.symbol] = w.code_bits;
                code_len_mem[w.symbol]  = LEN_W'(len);
            end
            FUNC_ENCODE:
            begin
                cw  = code_word_mem[w.symbol];
                len = code_len_mem[w.symbol];
                if (len > LEN_CAP)
                    len = LEN_CAP;
                // first code bit is the highest one; a full byte leaves
                // only when the next bit shows up
                for (int i = len; i > 0; i--)
                begin
                    if (acc_count >= BYTE_W)
                    begin
                        if (n < MAX_BYTES)
                        begin
                            queue_byte(acc_byte, 1'b0);
                            n++;
                        end
                        acc_byte  = '0;
                        acc_count = 0;
                    end
                    if (cw[i-1])
                        acc_byte = acc_byte | (8'h80 >> acc_count);
                    acc_count++;
                end
            end
            FUNC_FLUSH:
            begin
                queue_byte(acc_byte, 1'b1);
                n         = 1;
                acc_byte  = '0;
                acc_count = 0;
            end
            default:
            begin
            end
        endcase
        return n;
    endfunction

    // Offer one word, wait for it to be taken, then predict its bytes
    task automatic send_word(input code_req_t w, input logic typed, input byte_rec_t want);
        int gap;
        int n;
        gap = draw_wait();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid   <= 1'b1;
        func        <= w.func;
        symbol      <= w.symbol;
        code_bits   <= w.code_bits;
        code_length <= w.code_length;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        n = pack_word(w);
        // typed rows stand in for the single byte the model produced
        if (typed)
        begin
            repeat (n) void'(expected_bytes.pop_back());
            expected_bytes.push_back(want);
        end
    endtask

    // Output side: random stall, then check each accepted byte in order
    initial
    begin
        byte_rec_t want;
        int        hold;
        rsp_stall <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            hold = draw_wait();
            if (hold > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            @(posedge clk);
            while (!rsp_valid)
                @(posedge clk);
            if (expected_bytes.size() == 0)
                flag_mismatch($sformatf("unexpected byte %02h last %0b count %0d",
                                        out_byte, is_last, bytes_written));
            else
            begin
                want = expected_bytes.pop_front();
                if (out_byte !== want.value)
                    flag_mismatch($sformatf("out_byte %02h, want %02h",
                                            out_byte, want.value));
                if (is_last !== want.last)
                    flag_mismatch($sformatf("is_last %0b, want %0b on byte %02h",
                                            is_last, want.last, want.value));
                if (bytes_written !== want.total)
                    flag_mismatch($sformatf("bytes_written %0d, want %0d",
                                            bytes_written, want.total));
            end
        end
    end

    // Stimulus
    initial
    begin
        code_req_t req;
        int        pick;
        rst_n       <= 1'b0;
        req_valid   <= 1'b0;
        func        <= FUNC_LOAD;
        symbol      <= '0;
        code_bits   <= '0;
        code_length <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int r = 0; r < N_DIRECTED; r++)
            send_word(DIRECTED[r].req, DIRECTED[r].typed, DIRECTED[r].want);
        loaded_syms = '{8'hFF, 8'h00, 8'h01, 8'h80, 8'h7F, 8'h02};

        // random stream: mostly loads and encodes of loaded symbols
        for (int i = 0; i < N_RANDOM; i++)
        begin
            steady          = ((i / 40) % 2) == 1;
            req.symbol      = SYM_W'($urandom_range(0, 255));
            req.code_bits   = $urandom;
            req.code_length = LEN_W'($urandom_range(0, 63));
            pick            = $urandom_range(0, 99);
            if (pick < 25)
            begin
                req.func = FUNC_LOAD;
                pick     = $urandom_range(0, 9);
                // short codes dominate, a few long or overlong ones
                if (pick < 6)
                    req.code_length = LEN_W'($urandom_range(1, 12));
                else if (pick < 8)
                    req.code_length = LEN_W'($urandom_range(13, 32));
                loaded_syms.push_back(req.symbol);
            end
            else if (pick < 85)
            begin
                req.func = FUNC_ENCODE;
                if ($urandom_range(0, 9) < 8)
                    req.symbol = SYM_W'(loaded_syms[$urandom_range(0, loaded_syms.size() - 1)]);
            end
            else if (pick < 95)
                req.func = FUNC_FLUSH;
            else
                req.func = FUNC_UNUSED;
            send_word(req, 1'b0, NO_BYTE);
        end
        req_valid <= 1'b0;

        // drain, then give words without output time to misbehave
        steady = 1'b1;
        while (expected_bytes.size() > 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
